### rtl/tkz_pkg.sv
// ----------------------------------------------------------------------------
// tkz_pkg
// Shared types for the assembly source tokenizer: request and result
// payloads, token kinds, lexer modes and the lexer state.
// ----------------------------------------------------------------------------
package tkz_pkg;

  typedef enum logic [3:0] {
    K_BLANK   = 4'd0,
    K_NEWLINE = 4'd1,
    K_OPEN    = 4'd2,
    K_CLOSE   = 4'd3,
    K_COLON   = 4'd4,
    K_DOLLAR  = 4'd5,
    K_COMMENT = 4'd6,
    K_STRING  = 4'd7,
    K_HEX     = 4'd8,
    K_BIN     = 4'd9,
    K_DEC     = 4'd10,
    K_IDENT   = 4'd11,
    K_ERROR   = 4'd12
  } kind_t;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_COMMENT = 4'd1,
    M_STRING  = 4'd2,
    M_HEXPFX  = 4'd3,
    M_HEX     = 4'd4,
    M_BINPFX  = 4'd5,
    M_BIN     = 4'd6,
    M_DEC     = 4'd7,
    M_IDENT   = 4'd8
  } mode_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } tkz_in_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_value;
    kind_t      kind;
    logic       starts_token;
    logic [7:0] trim_count;
    logic       is_last;
  } tkz_out_t;

  // Lexer control state carried between bytes
  typedef struct packed {
    mode_t mode;
    logic  error_seen;
  } lex_state_t;

endpackage

### rtl/tkz_label.sv
// ----------------------------------------------------------------------------
// tkz_label
// Labels the held byte using the incoming byte as lookahead, and computes
// the next lexer state.
// ----------------------------------------------------------------------------
module tkz_label #(
  parameter int TRIM_COUNT_BITS = 8
) (
  input  logic [7:0]                 held_byte,
  input  logic                       held_valid,
  input  logic [7:0]                 next_byte,
  input  logic                       end_of_text,
  input  tkz_pkg::lex_state_t        state,
  input  logic [TRIM_COUNT_BITS-1:0] blank_run,
  output logic                       res_valid,
  output tkz_pkg::tkz_out_t          res,
  output tkz_pkg::lex_state_t        state_nxt,
  output logic [TRIM_COUNT_BITS-1:0] blank_run_nxt
);
  import tkz_pkg::*;

  localparam int RunW = (TRIM_COUNT_BITS > 8) ? TRIM_COUNT_BITS : 8;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0D};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == 8'h5F);
  endfunction

  function automatic logic is_hexd(input logic [7:0] c);
    return is_digit(c) || (c inside {[8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  logic [RunW-1:0] run_ext;
  kind_t           kind;
  logic            starts;
  logic [7:0]      trim;
  logic            done;
  logic            la_ok;

  assign run_ext = RunW'(blank_run);
  assign la_ok   = !end_of_text;

  always_comb begin
    kind          = K_ERROR;
    starts        = 1'b0;
    trim          = 8'd0;
    done          = 1'b0;
    state_nxt     = state;
    blank_run_nxt = blank_run;

    if (state.error_seen) begin
      done = 1'b1;
    end else begin
      case (state.mode)
        M_COMMENT: begin
          if (held_byte != 8'h0A) begin
            kind = K_COMMENT;
            done = 1'b1;
            if (is_blank(held_byte)) begin
              if (blank_run != '1) blank_run_nxt = blank_run + 1'b1;
            end else begin
              blank_run_nxt = '0;
            end
          end else begin
            trim = (run_ext > RunW'(255)) ? 8'hFF : run_ext[7:0];
            blank_run_nxt = '0;
            state_nxt.mode = M_IDLE;
          end
        end
        M_STRING: begin
          kind = K_STRING;
          done = 1'b1;
          if (held_byte == 8'h22) state_nxt.mode = M_IDLE;
        end
        M_HEXPFX: begin
          kind = K_HEX; state_nxt.mode = M_HEX; done = 1'b1;
        end
        M_BINPFX: begin
          kind = K_BIN; state_nxt.mode = M_BIN; done = 1'b1;
        end
        M_HEX: if (is_hexd(held_byte)) begin
          kind = K_HEX; done = 1'b1;
        end
        M_BIN: if (held_byte == 8'h30 || held_byte == 8'h31) begin
          kind = K_BIN; done = 1'b1;
        end
        M_DEC: if (is_digit(held_byte)) begin
          kind = K_DEC; done = 1'b1;
        end
        M_IDENT: if (is_word(held_byte)) begin
          kind = K_IDENT; done = 1'b1;
        end
        default: ;
      endcase

      // Start of a new token from the idle position
      if (!done) begin
        state_nxt.mode = M_IDLE;
        starts = 1'b1;
        if (is_blank(held_byte)) begin
          kind = K_BLANK; starts = 1'b0;
        end else if (held_byte == 8'h0A) kind = K_NEWLINE;
        else if (held_byte == 8'h7B) kind = K_OPEN;
        else if (held_byte == 8'h7D) kind = K_CLOSE;
        else if (held_byte == 8'h3A) kind = K_COLON;
        else if (held_byte == 8'h24) kind = K_DOLLAR;
        else if (held_byte == 8'h2D && la_ok && next_byte == 8'h2D) begin
          kind = K_COMMENT; state_nxt.mode = M_COMMENT; blank_run_nxt = '0;
        end else if (held_byte == 8'h22) begin
          kind = K_STRING; state_nxt.mode = M_STRING;
        end else if (held_byte == 8'h30 && la_ok && (next_byte == 8'h78 || next_byte == 8'h58))
        begin
          kind = K_HEX; state_nxt.mode = M_HEXPFX;
        end else if (held_byte == 8'h30 && la_ok && (next_byte == 8'h62 || next_byte == 8'h42))
        begin
          kind = K_BIN; state_nxt.mode = M_BINPFX;
        end else if (is_alpha(held_byte) || held_byte == 8'h5F) begin
          kind = K_IDENT; state_nxt.mode = M_IDENT;
        end else if (is_digit(held_byte)) begin
          kind = K_DEC; state_nxt.mode = M_DEC;
        end else begin
          kind = K_ERROR; state_nxt.error_seen = 1'b1;
        end
      end
    end

    // Unterminated string at end of text
    if (end_of_text && !state_nxt.error_seen && state_nxt.mode == M_STRING) begin
      kind = K_ERROR;
      state_nxt.error_seen = 1'b1;
    end

    res.char_valid   = held_valid;
    res.char_value   = held_byte;
    res.kind         = kind;
    res.starts_token = starts;
    res.trim_count   = trim;
    res.is_last      = end_of_text;

    // Nothing held: state kept (apart from the end-of-text reset below), empty result
    if (!held_valid) begin
      state_nxt          = state;
      blank_run_nxt      = blank_run;
      res.char_value     = 8'd0;
      res.kind           = K_BLANK;
      res.starts_token   = 1'b0;
      res.trim_count     = 8'd0;
    end

    if (end_of_text) begin
      state_nxt.mode = M_IDLE;
      blank_run_nxt  = '0;
    end
  end

  assign res_valid = end_of_text || held_valid;

endmodule

### rtl/tkz_out_buf.sv
// ----------------------------------------------------------------------------
// tkz_out_buf
// Two-entry result buffer: output register plus skid register, so the
// lexer can still hand over one more result after the receiver stalls.
// ----------------------------------------------------------------------------
module tkz_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tkz_pkg::tkz_out_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output tkz_pkg::tkz_out_t out_data
);
  import tkz_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  tkz_out_t out_data_r, out_data_nxt;
  tkz_out_t skid_data_r, skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && !out_ready) begin
      if (push) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = push;
      skid_data_nxt  = push_data;
    end else begin
      out_valid_nxt = push;
      out_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/assembly_source_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_unit
// Byte-serial assembly lexer: labels each source byte with its token kind.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one source byte per
//   request, or an end-of-text marker. Each byte is held one request so the
//   next byte serves as lookahead; the held byte is labelled when the next
//   request (byte or end marker) arrives. The end marker always yields one
//   result with is_last set, flushing the held byte if there is one.
//   Output channel (out_valid/out_ready/out_data) carries the labels.
// Results: a label is registered into the result buffer when the request
//   that caused it is accepted (one request later than its own byte).
// Throughput: one request per cycle while in_ready is high; the lexer mode
//   update between the held-byte and result registers is combinational.
// Stall: results go into a two-entry buffer; in_ready drops only when both
//   entries are full, and resumes the cycle after the receiver takes one.
// Reset (rst_n low, synchronous): no held byte, lexer idle, blank run and
//   the sticky error flag cleared, result buffer empty.
// The error flag survives end markers; only reset clears it.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_unit #(
  parameter int TRIM_COUNT_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tkz_pkg::tkz_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tkz_pkg::tkz_out_t out_data
);
  import tkz_pkg::*;

  // Lookahead holding register and lexer state
  logic [7:0]                 held_byte_r, held_byte_nxt;
  logic                       held_valid_r, held_valid_nxt;
  lex_state_t                 state_r, state_nxt;
  logic [TRIM_COUNT_BITS-1:0] blank_run_r, blank_run_nxt;

  logic       in_fire;
  logic       res_valid;
  tkz_out_t   res;
  lex_state_t lab_state;
  logic [TRIM_COUNT_BITS-1:0] lab_blank_run;
  logic       can_push;

  assign in_fire = in_valid && in_ready;
  assign in_ready = can_push;

  tkz_label #(
    .TRIM_COUNT_BITS(TRIM_COUNT_BITS)
  ) u_label (
    .held_byte    (held_byte_r),
    .held_valid   (held_valid_r),
    .next_byte    (in_data.char_byte),
    .end_of_text  (in_data.end_of_text),
    .state        (state_r),
    .blank_run    (blank_run_r),
    .res_valid    (res_valid),
    .res          (res),
    .state_nxt    (lab_state),
    .blank_run_nxt(lab_blank_run)
  );

  // State only advances on an accepted request
  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    state_nxt      = state_r;
    blank_run_nxt  = blank_run_r;
    if (in_fire) begin
      state_nxt     = lab_state;
      blank_run_nxt = lab_blank_run;
      if (in_data.end_of_text) begin
        held_byte_nxt  = 8'd0;
        held_valid_nxt = 1'b0;
      end else begin
        held_byte_nxt  = in_data.char_byte;
        held_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r  <= 8'd0;
      held_valid_r <= 1'b0;
      state_r      <= '{mode: M_IDLE, error_seen: 1'b0};
      blank_run_r  <= '0;
    end else begin
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      state_r      <= state_nxt;
      blank_run_r  <= blank_run_nxt;
    end
  end

  tkz_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire && res_valid),
    .push_data(res),
    .can_push (can_push),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
